// ----- src/ple_pkg.sv -----
package ple_pkg;

	// List geometry
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int CMD_W    = 2;
	localparam int POS_W    = 11;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;

	// Width used for position range checks (room for count + 1)
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// What every cell does in the current cycle
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_POST = 2'd2
	} ctrl_state_t;

	// Broadcast from the controller to the row of cells
	typedef struct packed {
		cell_op_t                 op;
		logic [IDX_W-1:0]         p0;     // 0-based target slot
		logic [IDX_W-1:0]         last;   // 0-based last occupied slot
		logic signed [VAL_W-1:0]  value;  // value to insert
	} cell_ctl_t;

endpackage

// ----- src/positional_list_engine_top.sv -----
// Channel  Handshake            Beat fields
// input    in_valid / in_stall  cmd, position, value
// output   out_valid / out_stall read_value, found_position, status, entry_count
//
// Insert, delete, any range/full error and find on an empty list are answered from idle without a scan.
// Get and find: the row of cells rotates as a ring through slot 0 once per entry,
// so the scan length is set by the current entry count.
// Reset clears the count and handshake state only; slot contents are never read
// before they are written.
// A stalled output holds its beat; the input stalls while a scan runs or while the
// output register is full and stalled.
module positional_list_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ple_pkg::CMD_W-1:0]        cmd,
	input  logic [ple_pkg::POS_W-1:0]        position,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ple_pkg::VAL_W-1:0] read_value,
	output logic [ple_pkg::POS_W-1:0]        found_position,
	output logic [ple_pkg::STAT_W-1:0]       status,
	output logic [ple_pkg::POS_W-1:0]        entry_count
);

	ple_pkg::cell_ctl_t               cell_ctl;
	logic signed [ple_pkg::VAL_W-1:0] cell_data [ple_pkg::CAPACITY];

	// Sequencer, count and result register
	ple_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.position       (position),
		.value          (value),
		.head_data      (cell_data[0]),
		.cell_ctl       (cell_ctl),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.found_position (found_position),
		.status         (status),
		.entry_count    (entry_count)
	);

	// Row of list slots; the ends tie their missing neighbor to the insert value
	for (genvar k = 0; k < ple_pkg::CAPACITY; k++) begin : g_cell
		logic signed [ple_pkg::VAL_W-1:0] left_d, right_d;

		if (k == 0) begin : g_first
			assign left_d = cell_ctl.value;
		end else begin : g_left
			assign left_d = cell_data[k-1];
		end

		if (k == ple_pkg::CAPACITY - 1) begin : g_last
			assign right_d = cell_ctl.value;
		end else begin : g_right
			assign right_d = cell_data[k+1];
		end

		ple_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.idx        (ple_pkg::IDX_W'(k)),
			.left_data  (left_d),
			.right_data (right_d),
			.head_data  (cell_data[0]),
			.data       (cell_data[k])
		);
	end

endmodule

// ----- src/ple_cell.sv -----
module ple_cell (
	input  logic                            clk,
	input  ple_pkg::cell_ctl_t              ctl,
	input  logic [ple_pkg::IDX_W-1:0]       idx,
	input  logic signed [ple_pkg::VAL_W-1:0] left_data,
	input  logic signed [ple_pkg::VAL_W-1:0] right_data,
	input  logic signed [ple_pkg::VAL_W-1:0] head_data,
	output logic signed [ple_pkg::VAL_W-1:0] data
);

	logic signed [ple_pkg::VAL_W-1:0] data_q;

	// One list slot: shift up on insert, down on delete, ring-rotate toward slot 0 on scan
	always_ff @(posedge clk) begin
		case (ctl.op)
			ple_pkg::OP_INSERT: begin
				if (idx == ctl.p0)
					data_q <= ctl.value;
				else if (idx > ctl.p0)
					data_q <= left_data;
			end
			ple_pkg::OP_DELETE: begin
				if (idx >= ctl.p0)
					data_q <= right_data;
			end
			ple_pkg::OP_ROTATE: begin
				// last occupied slot closes the ring with the head
				if (idx == ctl.last)
					data_q <= head_data;
				else if (idx < ctl.last)
					data_q <= right_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ----- src/ple_ctrl.sv -----
module ple_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ple_pkg::CMD_W-1:0]        cmd,
	input  logic [ple_pkg::POS_W-1:0]        position,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	input  logic signed [ple_pkg::VAL_W-1:0] head_data,
	output ple_pkg::cell_ctl_t               cell_ctl,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ple_pkg::VAL_W-1:0] read_value,
	output logic [ple_pkg::POS_W-1:0]        found_position,
	output logic [ple_pkg::STAT_W-1:0]       status,
	output logic [ple_pkg::POS_W-1:0]        entry_count
);

	ple_pkg::ctrl_state_t state_q, state_d;
	logic [ple_pkg::CNT_W-1:0]        count_q, count_d;
	logic [ple_pkg::IDX_W-1:0]        step_q, step_d;
	logic signed [ple_pkg::VAL_W-1:0] rd_q, rd_d;
	logic [ple_pkg::CNT_W-1:0]        found_q, found_d;

	// Beat captured for a scan
	ple_pkg::cmd_t                    cmd_q;
	logic [ple_pkg::IDX_W-1:0]        p0_q;
	logic signed [ple_pkg::VAL_W-1:0] key_q;

	// Output register
	logic                             out_valid_q;
	logic signed [ple_pkg::VAL_W-1:0] out_rd_q;
	logic [ple_pkg::POS_W-1:0]        out_found_q;
	ple_pkg::status_t                 out_status_q;
	logic [ple_pkg::POS_W-1:0]        out_count_q;

	logic                             load;
	logic signed [ple_pkg::VAL_W-1:0] ld_rd;
	logic [ple_pkg::CNT_W-1:0]        ld_found;
	ple_pkg::status_t                 ld_status;
	logic [ple_pkg::CNT_W-1:0]        ld_count;

	logic                             out_free, accept;
	logic [ple_pkg::CMP_W-1:0]        pos_x, cnt_x;
	logic                             rng_bad, ins_bad, list_full, ins_ok;
	logic [ple_pkg::IDX_W-1:0]        p0;
	logic                             step_last;

	// Handshake and range checks
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ple_pkg::ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;

	assign pos_x     = ple_pkg::CMP_W'(position);
	assign cnt_x     = ple_pkg::CMP_W'(count_q);
	assign rng_bad   = (position == '0) || (pos_x > cnt_x);
	assign ins_bad   = (position == '0) || (pos_x > (cnt_x + ple_pkg::CMP_W'(1)));
	assign list_full = count_q >= ple_pkg::CNT_W'(ple_pkg::CAPACITY);
	assign ins_ok    = !ins_bad && !list_full;
	assign p0        = ple_pkg::IDX_W'(position - ple_pkg::POS_W'(1));
	assign step_last = step_q == ple_pkg::IDX_W'(count_q - ple_pkg::CNT_W'(1));

	// Next state, cell command and result load
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		step_d         = step_q;
		rd_d           = rd_q;
		found_d        = found_q;
		cell_ctl.op    = ple_pkg::OP_HOLD;
		cell_ctl.p0    = p0;
		cell_ctl.last  = ple_pkg::IDX_W'(count_q - ple_pkg::CNT_W'(1));
		cell_ctl.value = value;
		load           = 1'b0;
		ld_rd          = '0;
		ld_found       = '0;
		ld_status      = ple_pkg::STAT_OK;
		ld_count       = count_q;
		unique case (state_q)
			ple_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (ple_pkg::cmd_t'(cmd))
						ple_pkg::CMD_GET: begin
							if (rng_bad) begin
								load      = 1'b1;
								ld_status = ple_pkg::STAT_RANGE;
							end else begin
								state_d = ple_pkg::ST_SCAN;
								step_d  = '0;
								rd_d    = '0;
								found_d = '0;
							end
						end
						ple_pkg::CMD_FIND: begin
							if (count_q == '0) begin
								load = 1'b1;
							end else begin
								state_d = ple_pkg::ST_SCAN;
								step_d  = '0;
								rd_d    = '0;
								found_d = '0;
							end
						end
						ple_pkg::CMD_INSERT: begin
							load = 1'b1;
							if (ins_bad) begin
								ld_status = ple_pkg::STAT_RANGE;
							end else if (list_full) begin
								ld_status = ple_pkg::STAT_FULL;
							end else begin
								cell_ctl.op = ple_pkg::OP_INSERT;
								count_d     = count_q + ple_pkg::CNT_W'(1);
								ld_count    = count_d;
							end
						end
						ple_pkg::CMD_DELETE: begin
							load = 1'b1;
							if (rng_bad) begin
								ld_status = ple_pkg::STAT_RANGE;
							end else begin
								cell_ctl.op = ple_pkg::OP_DELETE;
								count_d     = count_q - ple_pkg::CNT_W'(1);
								ld_count    = count_d;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			ple_pkg::ST_SCAN: begin
				// slot 0 holds entry step_q; once every entry has passed slot 0 the ring is back in order
				cell_ctl.op = ple_pkg::OP_ROTATE;
				if (cmd_q == ple_pkg::CMD_GET && step_q == p0_q)
					rd_d = head_data;
				if (cmd_q == ple_pkg::CMD_FIND && found_q == '0 && head_data == key_q)
					found_d = ple_pkg::CNT_W'(step_q) + ple_pkg::CNT_W'(1);
				step_d = step_q + ple_pkg::IDX_W'(1);
				if (step_last)
					state_d = ple_pkg::ST_POST;
			end
			ple_pkg::ST_POST: begin
				if (out_free) begin
					load     = 1'b1;
					ld_rd    = rd_q;
					ld_found = found_q;
					state_d  = ple_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ple_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Scan working registers and captured beat
	always_ff @(posedge clk) begin
		step_q  <= step_d;
		rd_q    <= rd_d;
		found_q <= found_d;
		if (accept) begin
			cmd_q <= ple_pkg::cmd_t'(cmd);
			p0_q  <= p0;
			key_q <= value;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			out_rd_q     <= ld_rd;
			out_found_q  <= ple_pkg::POS_W'(ld_found);
			out_status_q <= ld_status;
			out_count_q  <= ple_pkg::POS_W'(ld_count);
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = out_rd_q;
	assign found_position = out_found_q;
	assign status         = out_status_q;
	assign entry_count    = out_count_q;

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ple_pkg::ST_SCAN) |-> (ple_pkg::CNT_W'(step_q) < count_q))
		else $error("scan step past last entry");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ple_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_INSERT && ins_ok)
		|=> (count_q == $past(count_q) + ple_pkg::CNT_W'(1)))
		else $error("insert did not grow list");

	a_scan_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ple_pkg::ST_SCAN) |=> $stable(count_q))
		else $error("count changed during scan");
`endif

endmodule
